/* rtl/framebuffer_register_and_pixel_port_unit_macros.svh */
// ----------------------------------------------------------------------------
// Frame buffer unit assertion macros
// Concurrent check macros for the frame buffer register and pixel port unit.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_REGISTER_AND_PIXEL_PORT_UNIT_MACROS_SVH
`define FRAMEBUFFER_REGISTER_AND_PIXEL_PORT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent
`define FBPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent
`define FBPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBPP_ASSERT_NOW(lbl, ante, cons, msg)
`define FBPP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/fbpp_pkg.sv */
// ----------------------------------------------------------------------------
// Frame buffer unit package
// Bus decode constants, register offsets, reset values and stage types for
// the frame buffer register and pixel port unit.
// ----------------------------------------------------------------------------
package fbpp_pkg;

    // Bus window
    localparam logic [31:0] BASE_ADDRESS  = 32'h3000_0000;
    localparam logic [31:0] REG_WINDOW    = 32'h0000_1000;
    localparam logic [31:0] MAX_DIMENSION = 32'd2048;

    // Access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;

    // Register offsets
    localparam logic [31:0] REG_WIDTH  = 32'h0;
    localparam logic [31:0] REG_HEIGHT = 32'h4;
    localparam logic [31:0] REG_FORMAT = 32'h8;
    localparam logic [31:0] REG_FLUSH  = 32'hC;

    // Geometry reset values
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    // Stream widths
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    // Decoded access handed from the access stage to the assembly stage
    typedef struct packed {
        logic        mem_rd;
        logic [2:0]  lane_lo;
        logic [1:0]  size_log2;
        logic [11:0] reg_rdata;
        logic        bus_error;
        logic        display_changed;
        logic        geometry_changed;
    } s1_info_t;

endpackage

/* rtl/framebuffer_register_and_pixel_port_unit.sv */
// ----------------------------------------------------------------------------
// Frame buffer register and pixel port unit
// Bus target with width, height, format and flush registers and a
// byte-addressed pixel store split into eight byte banks.
// ----------------------------------------------------------------------------
// The unit takes one bus access per cycle while the output side does not stall
// and no clearing pass runs, and returns one result per access. Each result
// passes through the input stage, the assembly stage and the output register.
// The pixel store is eight byte-wide banks of STORE_BYTES/8 rows; an access of
// up to eight bytes at any byte offset touches each bank at most once, so every
// access needs at most one read or write per bank. After reset the unit clears
// the store one row per cycle and takes no access until the pass has finished.
`include "framebuffer_register_and_pixel_port_unit_macros.svh"

module framebuffer_register_and_pixel_port_unit #(
    parameter int STORE_BYTES = 1048576
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // address [31:0], size_log2 [33:32], write_data [97:34], zero fill above
    input  logic [fbpp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // kind [1:0]
    input  logic [fbpp_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_data [63:0], bus_error [64], display_changed [65],
    // geometry_changed [66], zero fill above
    output logic [fbpp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int ROWS  = (STORE_BYTES + 7) / 8;
    localparam int ROW_W = $clog2(ROWS);
    localparam int POS_W = $clog2(STORE_BYTES);
    localparam logic [32:0] WINDOW_END = 33'(fbpp_pkg::REG_WINDOW) + 33'(STORE_BYTES);
    localparam logic [POS_W:0] STORE_END = (POS_W+1)'(STORE_BYTES);

    // Handshake advance terms
    logic adv0;
    logic adv1;
    logic adv2;
    logic commit;

    // Clearing pass
    logic             clearing_reg;
    logic [ROW_W-1:0] clear_row_reg;

    // Input stage
    logic        s0_valid_reg;
    logic [1:0]  s0_kind_reg;
    logic [31:0] s0_addr_reg;
    logic [1:0]  s0_size_reg;
    logic [63:0] s0_wdata_reg;

    // Geometry registers
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic        pixel_format_reg;

    // Access stage decode
    logic [31:0]      offset;
    logic             is_access;
    logic             is_wr;
    logic             in_regs;
    logic             in_store;
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   pos_end;
    logic [3:0]       nbytes;
    logic             fits;
    logic             mem_op;
    logic [2:0]       lo;
    logic [7:0]       lane_mask;
    logic [15:0]      lane_wide;
    logic [7:0]       lane_en;
    logic [127:0]     wdata_wide;
    logic [63:0]      wdata_rot;
    logic [ROW_W-1:0] row_base;
    logic [31:0]      low32;
    logic             dim_ok;
    logic             fmt_ok;
    logic             width_wr;
    logic             height_wr;
    logic             format_wr;
    logic             flush_hit;
    fbpp_pkg::s1_info_t s1_next;

    // Bank ports
    logic [7:0]                  bank_we;
    logic [7:0]                  bank_re;
    logic [7:0][ROW_W-1:0]       bank_addr;
    logic [7:0][7:0]             bank_wd;
    logic [7:0][7:0]             bank_q;

    // Assembly stage
    logic               s1_valid_reg;
    fbpp_pkg::s1_info_t s1_info_reg;
    logic [127:0]       rd_wide;
    logic [63:0]        rd_rot;
    logic [7:0]         rd_bmask;
    logic [63:0]        rd_mask;
    logic [63:0]        read_data_next;

    // Output register
    logic        out_valid_reg;
    logic [63:0] out_rdata_reg;
    logic        out_err_reg;
    logic        out_disp_reg;
    logic        out_geom_reg;

    // Advance each stage when the stage after it is empty or moving
    assign adv2   = !out_valid_reg || m_axis_tready;
    assign adv1   = !s1_valid_reg || adv2;
    assign adv0   = !s0_valid_reg || adv1;
    assign commit = s0_valid_reg && adv1;

    assign s_axis_tready = adv0 && !clearing_reg;

    // Sweep the store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_row_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_row_reg <= clear_row_reg + ROW_W'(1);
            if (clear_row_reg == ROW_W'(ROWS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv0)
        begin
            s0_valid_reg <= s_axis_tvalid && s_axis_tready;
        end
    end

    // Capture the accepted transfer
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s0_kind_reg  <= s_axis_tuser[1:0];
            s0_addr_reg  <= s_axis_tdata[31:0];
            s0_size_reg  <= s_axis_tdata[33:32];
            s0_wdata_reg <= s_axis_tdata[97:34];
        end
    end

    // Decode window and byte lanes
    always_comb
    begin
        offset    = s0_addr_reg - fbpp_pkg::BASE_ADDRESS;
        is_access = (s0_kind_reg == fbpp_pkg::KIND_READ) ||
                    (s0_kind_reg == fbpp_pkg::KIND_WRITE);
        is_wr     = (s0_kind_reg == fbpp_pkg::KIND_WRITE);
        in_regs   = offset < fbpp_pkg::REG_WINDOW;
        in_store  = !in_regs && ({1'b0, offset} < WINDOW_END);
        pos       = POS_W'(offset - fbpp_pkg::REG_WINDOW);
        nbytes    = 4'd1 << s0_size_reg;
        pos_end   = {1'b0, pos} + (POS_W+1)'(nbytes);
        fits      = pos_end <= STORE_END;
        mem_op    = s0_valid_reg && is_access && in_store && fits;
        lo        = pos[2:0];
        row_base  = ROW_W'(pos >> 3);

        case (s0_size_reg)
            2'd0:    lane_mask = 8'h01;
            2'd1:    lane_mask = 8'h03;
            2'd2:    lane_mask = 8'h0F;
            default: lane_mask = 8'hFF;
        endcase
        lane_wide  = {lane_mask, lane_mask} << lo;
        lane_en    = lane_wide[15:8];
        wdata_wide = {s0_wdata_reg, s0_wdata_reg} << {lo, 3'b000};
        wdata_rot  = wdata_wide[127:64];
    end

    // Decode register writes
    always_comb
    begin
        low32     = s0_wdata_reg[31:0];
        dim_ok    = !low32[31] && (low32 != 32'd0) && (low32 <= fbpp_pkg::MAX_DIMENSION);
        fmt_ok    = (low32 == 32'd0) || (low32 == 32'd1);
        width_wr  = s0_valid_reg && is_wr && in_regs && (offset == fbpp_pkg::REG_WIDTH) &&
                    dim_ok && (low32 != {20'd0, frame_width_reg});
        height_wr = s0_valid_reg && is_wr && in_regs && (offset == fbpp_pkg::REG_HEIGHT) &&
                    dim_ok && (low32 != {20'd0, frame_height_reg});
        format_wr = s0_valid_reg && is_wr && in_regs && (offset == fbpp_pkg::REG_FORMAT) &&
                    fmt_ok && (low32[0] != pixel_format_reg);
        flush_hit = s0_valid_reg && is_wr && in_regs && (offset == fbpp_pkg::REG_FLUSH) &&
                    (s0_wdata_reg == 64'd1);
    end

    // Build the access stage result
    always_comb
    begin
        s1_next = '0;
        s1_next.mem_rd    = mem_op && !is_wr;
        s1_next.lane_lo   = lo;
        s1_next.size_log2 = s0_size_reg;
        if (s0_valid_reg && is_access && in_regs && !is_wr)
        begin
            case (offset)
                fbpp_pkg::REG_WIDTH:  s1_next.reg_rdata = frame_width_reg;
                fbpp_pkg::REG_HEIGHT: s1_next.reg_rdata = frame_height_reg;
                fbpp_pkg::REG_FORMAT: s1_next.reg_rdata = {11'd0, pixel_format_reg};
                default:              s1_next.reg_rdata = 12'd0;
            endcase
        end
        s1_next.bus_error        = s0_valid_reg && is_access && !in_regs && !in_store;
        s1_next.display_changed  = flush_hit || (mem_op && is_wr);
        s1_next.geometry_changed = width_wr || height_wr || format_wr;
    end

    // Update geometry on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= fbpp_pkg::WIDTH_RESET;
            frame_height_reg <= fbpp_pkg::HEIGHT_RESET;
            pixel_format_reg <= 1'b0;
        end
        else if (commit)
        begin
            if (width_wr)
            begin
                frame_width_reg <= low32[11:0];
            end
            if (height_wr)
            begin
                frame_height_reg <= low32[11:0];
            end
            if (format_wr)
            begin
                pixel_format_reg <= low32[0];
            end
        end
    end

    // Drive bank ports: clearing sweep or committed access
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            if (clearing_reg)
            begin
                bank_we[b]   = 1'b1;
                bank_re[b]   = 1'b0;
                bank_addr[b] = clear_row_reg;
                bank_wd[b]   = 8'd0;
            end
            else
            begin
                bank_we[b]   = commit && mem_op && is_wr && lane_en[b];
                bank_re[b]   = commit && mem_op && !is_wr && lane_en[b];
                bank_addr[b] = row_base + ROW_W'(3'(b) < lo);
                bank_wd[b]   = wdata_rot[8*b +: 8];
            end
        end
    end

    // Byte banks with registered read
    for (genvar gi = 0; gi < 8; gi++)
    begin : g_bank
        logic [7:0] mem_bank [ROWS];
        logic [7:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (bank_we[gi])
            begin
                mem_bank[bank_addr[gi]] <= bank_wd[gi];
            end
            else if (bank_re[gi])
            begin
                rd_reg <= mem_bank[bank_addr[gi]];
            end
        end

        assign bank_q[gi] = rd_reg;
    end

    // Assembly stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            s1_info_reg <= s1_next;
        end
    end

    // Rotate bank bytes back into order and trim to the access size
    always_comb
    begin
        rd_wide = {bank_q, bank_q} >> {s1_info_reg.lane_lo, 3'b000};
        rd_rot  = rd_wide[63:0];
        case (s1_info_reg.size_log2)
            2'd0:    rd_bmask = 8'h01;
            2'd1:    rd_bmask = 8'h03;
            2'd2:    rd_bmask = 8'h0F;
            default: rd_bmask = 8'hFF;
        endcase
        for (int i = 0; i < 8; i++)
        begin
            rd_mask[8*i +: 8] = {8{rd_bmask[i]}};
        end
        if (s1_info_reg.mem_rd)
        begin
            read_data_next = rd_rot & rd_mask;
        end
        else
        begin
            read_data_next = {52'd0, s1_info_reg.reg_rdata};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && adv2)
        begin
            out_rdata_reg <= read_data_next;
            out_err_reg   <= s1_info_reg.bus_error;
            out_disp_reg  <= s1_info_reg.display_changed;
            out_geom_reg  <= s1_info_reg.geometry_changed;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_geom_reg, out_disp_reg, out_err_reg, out_rdata_reg};

    // Checks
    `FBPP_ASSERT_NOW(a_clear_blocks_input, clearing_reg, !s_axis_tready && !m_axis_tvalid, "access taken during clearing pass")
    `FBPP_ASSERT_NOW(a_clear_pipe_empty, clearing_reg, !s0_valid_reg && !s1_valid_reg, "pipeline busy during clearing pass")
    `FBPP_ASSERT_NEXT(a_input_lands, s_axis_tvalid && s_axis_tready, s0_valid_reg, "accepted transfer lost at input stage")
    `FBPP_ASSERT_NEXT(a_bank_data_holds, s1_valid_reg && !adv2, $stable(bank_q), "bank read data changed under stall")
    `FBPP_ASSERT_NOW(a_width_range, 1'b1, (frame_width_reg != 12'd0) && (frame_height_reg != 12'd0) && (frame_width_reg <= 12'(fbpp_pkg::MAX_DIMENSION)) && (frame_height_reg <= 12'(fbpp_pkg::MAX_DIMENSION)), "geometry out of range")

endmodule
